// ----- rtl/huffman_predictive_raw_decode_core_defines.svh -----
// Assertion helpers for the decode core
`ifndef HUFFMAN_PREDICTIVE_RAW_DECODE_CORE_DEFINES_SVH
`define HUFFMAN_PREDICTIVE_RAW_DECODE_CORE_DEFINES_SVH

// same-cycle implication
`define HPRD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hprd assertion failed");

// next-cycle implication
`define HPRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hprd assertion failed");

`endif

// ----- rtl/hprd_pkg.sv -----
package hprd_pkg;

	localparam int TABLE_ENTRIES      = 32;
	localparam int MAX_CODE_BITS      = 8;
	localparam int MAX_MAGNITUDE_BITS = 16;
	localparam int MAX_DIMENSION      = 4096;

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int CNT_W  = 12;
	localparam int DIM_W  = 13;

	localparam logic ACT_TABLE = 1'b0;
	localparam logic ACT_DATA  = 1'b1;

	localparam logic [1:0] CFG_START_PRED = 2'd0;
	localparam logic [1:0] CFG_ROWS       = 2'd1;
	localparam logic [1:0] CFG_COLS       = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BIT,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic load_byte;
		logic tbl_we;
		logic step;
		logic push;
	} dp_cmd_t;

	typedef struct packed {
		logic got;
		logic eof;
		logic pend_valid;
	} dp_sts_t;

	typedef struct packed {
		logic        we;
		logic [1:0]  idx;
		logic [15:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [15:0] pixel_word;
		logic        decode_error;
		logic        end_of_frame;
	} pix_t;

endpackage

// ----- rtl/hprd_ifs.sv -----
interface hprd_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] byte_data;
	logic [4:0] entry_index;
	logic [3:0] entry_code_bits;
	logic [7:0] entry_code;
	logic [4:0] entry_magnitude_bits;
	modport source (output valid, action, byte_data, entry_index, entry_code_bits,
		entry_code, entry_magnitude_bits, input ready);
	modport sink (input valid, action, byte_data, entry_index, entry_code_bits,
		entry_code, entry_magnitude_bits, output ready);
endinterface

interface hprd_pixel_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_word;
	logic        decode_error;
	logic        end_of_frame;
	logic        last_of_byte;
	modport source (output valid, pixel_word, decode_error, end_of_frame, last_of_byte,
		input ready);
	modport sink (input valid, pixel_word, decode_error, end_of_frame, last_of_byte,
		output ready);
endinterface

interface hprd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/hprd_dp.sv -----
module hprd_dp
	import hprd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  cfg_wr_t     cfg,
	input  logic [7:0]  byte_data,
	input  logic [4:0]  entry_index,
	input  logic [3:0]  entry_code_bits,
	input  logic [7:0]  entry_code,
	input  logic [4:0]  entry_magnitude_bits,
	output dp_sts_t     sts,
	output pix_t        pend
);

	logic [3:0]  len_q  [TABLE_ENTRIES];
	logic [7:0]  code_q [TABLE_ENTRIES];
	logic [4:0]  mag_q  [TABLE_ENTRIES];

	logic [15:0] start_q;
	logic [DIM_W-1:0] rows_q, cols_q;
	logic [7:0]  byte_q;
	logic [7:0]  shift_q;
	logic [3:0]  ccnt_q;
	logic        mphase_q;
	logic [4:0]  mleft_q, mtotal_q;
	logic [15:0] macc_q;
	logic [15:0] cp_q [2];
	logic [15:0] rs_q [4];
	logic [CNT_W-1:0] row_q, col_q;
	logic        pend_v_q;
	pix_t        pend_q;

	logic        bit_in;
	logic [3:0]  plen;
	logic [7:0]  prefix;
	logic        exists, children, leaf;
	logic [4:0]  leaf_mag;
	logic [15:0] acc_n;
	logic [4:0]  left_n;
	logic [16:0] mask;
	logic [15:0] diff;
	logic        got, err, enter_mag;
	logic        c_par;
	logic [1:0]  slot;
	logic [15:0] pred, val;
	logic        col_last, row_last, eof;
	logic [DIM_W-1:0] dim_clamped;
	logic [3:0]  wr_len;
	logic [4:0]  wr_mag;

	assign bit_in = byte_q[7];

	always_comb begin
		plen     = ccnt_q + 4'd1;
		prefix   = {shift_q[6:0], bit_in};
		exists   = 1'b0;
		children = 1'b0;
		leaf     = 1'b0;
		leaf_mag = '0;
		// parallel match over all entries; higher index overrides
		for (int e = 0; e < TABLE_ENTRIES; e++) begin
			if (len_q[e] != 4'd0 && len_q[e] >= plen &&
				(code_q[e] >> (4'd8 - plen)) == prefix) begin
				exists = 1'b1;
				if (len_q[e] > plen) begin
					children = 1'b1;
				end else begin
					leaf     = 1'b1;
					leaf_mag = mag_q[e];
				end
			end
		end

		acc_n  = {macc_q[14:0], bit_in};
		left_n = (mleft_q != 5'd0) ? mleft_q - 5'd1 : 5'd0;
		mask   = (17'd1 << mtotal_q) - 17'd1;
		diff   = '0;
		got    = 1'b0;
		err    = 1'b0;
		enter_mag = 1'b0;
		if (mphase_q) begin
			if (left_n == 5'd0) begin
				got  = 1'b1;
				diff = acc_n[4'(mtotal_q - 5'd1)] ? acc_n : acc_n - mask[15:0];
			end
		end else if (!exists) begin
			got = 1'b1;
			err = 1'b1;
		end else if (!children && leaf) begin
			if (leaf_mag == 5'd0) got = 1'b1;
			else enter_mag = 1'b1;
		end

		c_par    = col_q[0];
		slot     = {row_q[0], c_par};
		pred     = (col_q < CNT_W'(2)) ? rs_q[slot] : cp_q[c_par];
		val      = pred + diff;
		col_last = (DIM_W'(col_q) + DIM_W'(1)) >= cols_q;
		row_last = (DIM_W'(row_q) + DIM_W'(1)) >= rows_q;
		eof      = col_last && row_last;

		if (cfg.data[DIM_W-1:0] == '0) dim_clamped = DIM_W'(1);
		else if (cfg.data[DIM_W-1:0] > DIM_W'(MAX_DIMENSION)) dim_clamped = DIM_W'(MAX_DIMENSION);
		else dim_clamped = cfg.data[DIM_W-1:0];

		wr_len = (entry_code_bits > 4'(MAX_CODE_BITS)) ? 4'(MAX_CODE_BITS) : entry_code_bits;
		wr_mag = (entry_magnitude_bits > 5'(MAX_MAGNITUDE_BITS)) ?
			5'(MAX_MAGNITUDE_BITS) : entry_magnitude_bits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < TABLE_ENTRIES; e++) len_q[e] <= '0;
		end else if (cmd.tbl_we && 32'(entry_index) < TABLE_ENTRIES) begin
			len_q[IDX_W'(entry_index)] <= wr_len;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl_we && 32'(entry_index) < TABLE_ENTRIES) begin
			code_q[IDX_W'(entry_index)] <= entry_code;
			mag_q[IDX_W'(entry_index)]  <= wr_mag;
		end
		if (cmd.load_byte) byte_q <= byte_data;
		else if (cmd.step) byte_q <= {byte_q[6:0], 1'b0};
		if (cmd.step && got) begin
			pend_q.pixel_word   <= {val[7:0], val[15:8]};
			pend_q.decode_error <= err;
			pend_q.end_of_frame <= eof;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			rows_q   <= DIM_W'(1);
			cols_q   <= DIM_W'(1);
			shift_q  <= '0;
			ccnt_q   <= '0;
			mphase_q <= 1'b0;
			mleft_q  <= '0;
			mtotal_q <= '0;
			macc_q   <= '0;
			cp_q[0]  <= '0;
			cp_q[1]  <= '0;
			for (int i = 0; i < 4; i++) rs_q[i] <= '0;
			row_q    <= '0;
			col_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (cfg.we) begin
				unique case (cfg.idx)
					CFG_START_PRED: begin
						start_q <= cfg.data;
						for (int i = 0; i < 4; i++) rs_q[i] <= cfg.data;
					end
					CFG_ROWS: rows_q <= dim_clamped;
					CFG_COLS: cols_q <= dim_clamped;
					default: ;
				endcase
			end
			if (cmd.step) begin
				if (got) begin
					shift_q  <= '0;
					ccnt_q   <= '0;
					mphase_q <= 1'b0;
					mleft_q  <= '0;
					mtotal_q <= '0;
					macc_q   <= '0;
					cp_q[c_par] <= val;
					if (col_q < CNT_W'(2) && !eof) rs_q[slot] <= val;
					if (col_last) begin
						col_q <= '0;
						if (row_last) begin
							row_q <= '0;
							for (int i = 0; i < 4; i++) rs_q[i] <= start_q;
						end else begin
							row_q <= row_q + CNT_W'(1);
						end
					end else begin
						col_q <= col_q + CNT_W'(1);
					end
				end else if (mphase_q) begin
					macc_q  <= acc_n;
					mleft_q <= left_n;
				end else if (enter_mag) begin
					shift_q  <= '0;
					ccnt_q   <= '0;
					mphase_q <= 1'b1;
					mtotal_q <= leaf_mag;
					mleft_q  <= leaf_mag;
					macc_q   <= '0;
				end else begin
					// prefix of a longer code
					shift_q <= prefix;
					ccnt_q  <= plen;
				end
			end
			if (cmd.step && got) pend_v_q <= 1'b1;
			else if (cmd.push) pend_v_q <= 1'b0;
		end
	end

	assign sts.got        = got;
	assign sts.eof        = eof;
	assign sts.pend_valid = pend_v_q;
	assign pend           = pend_q;

endmodule

// ----- rtl/hprd_ctrl.sv -----
`include "huffman_predictive_raw_decode_core_defines.svh"

module hprd_ctrl
	import hprd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_action,
	output logic    in_ready,
	input  logic    out_free,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    push_last
);

	ctrl_state_t state_q, state_d;
	logic [2:0]  bit_q, bit_d;
	logic        in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			bit_q   <= bit_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		bit_d     = bit_q;
		cmd       = '0;
		push_last = 1'b0;
		in_ready  = 1'b0;
		in_fire   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				in_fire  = in_valid;
				if (in_valid) begin
					if (in_action == ACT_DATA) begin
						cmd.load_byte = 1'b1;
						bit_d         = 3'd7;
						state_d       = S_BIT;
					end else begin
						cmd.tbl_we = 1'b1;
					end
				end
			end
			S_BIT: begin
				// a new pixel needs the pending one moved out first
				cmd.step = !(sts.got && sts.pend_valid && !out_free);
				cmd.push = cmd.step && sts.got && sts.pend_valid;
				if (cmd.step) begin
					if ((sts.got && sts.eof) || bit_q == 3'd0) state_d = S_DONE;
					else bit_d = bit_q - 3'd1;
				end
			end
			S_DONE: begin
				cmd.push  = sts.pend_valid && out_free;
				push_last = 1'b1;
				if (!sts.pend_valid || out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	`HPRD_ASSERT_IMPL(a_push_free, clk, arst_n, cmd.push, out_free)
	`HPRD_ASSERT_NEXT(a_data_starts, clk, arst_n, in_fire && in_action == ACT_DATA,
		state_q == S_BIT && bit_q == 3'd7)
	`HPRD_ASSERT_NEXT(a_done_drains, clk, arst_n, state_q == S_DONE && !sts.pend_valid,
		state_q == S_IDLE)
	`HPRD_ASSERT_IMPL(a_push_has_pend, clk, arst_n, cmd.push, sts.pend_valid)

endmodule

// ----- rtl/huffman_predictive_raw_decode_core.sv -----
// Huffman difference decoder with two-column-back predictor.
// item channel: action 0 writes a code table entry, action 1 brings an
// encoded byte, decoded MSB first at one bit per cycle while not stalled.
// pixel channel: up to eight pixels per byte, each byte-swapped, with
// decode_error, end_of_frame and last_of_byte flags.
// cfg channel: start_predictor, frame_rows, frame_cols; always ready, to be
// written only while the block is idle.
// A data byte is decoded in bit steps and its last pixel released before
// the item channel is ready again; the byte ends early when the frame ends.
// A pixel waits in the pending register until the next pixel is decoded or
// the byte ends, so last_of_byte is known; the output register follows.
// When the receiver stalls, decoding pauses at the next pixel that needs the
// output slot; the item channel stays closed until the byte is finished.
// Reset disables all table entries, clears the decode state and counters and
// loads zero into the row-start predictors.
module huffman_predictive_raw_decode_core
	import hprd_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	hprd_item_if.sink     item,
	hprd_pixel_if.source  pixel,
	hprd_cfg_if.sink      cfg
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	cfg_wr_t cfg_wr;
	pix_t    pend;
	logic    push_last;
	logic    out_free;
	logic    out_valid_q;
	pix_t    out_q;
	logic    out_last_q;

	assign cfg.ready   = 1'b1;
	assign cfg_wr.we   = cfg.valid;
	assign cfg_wr.idx  = cfg.index;
	assign cfg_wr.data = cfg.data;

	assign out_free = !out_valid_q || pixel.ready;

	hprd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_action (item.action),
		.in_ready  (item.ready),
		.out_free  (out_free),
		.sts       (sts),
		.cmd       (cmd),
		.push_last (push_last)
	);

	hprd_dp u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.cfg                  (cfg_wr),
		.byte_data            (item.byte_data),
		.entry_index          (item.entry_index),
		.entry_code_bits      (item.entry_code_bits),
		.entry_code           (item.entry_code),
		.entry_magnitude_bits (item.entry_magnitude_bits),
		.sts                  (sts),
		.pend                 (pend)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q      <= pend;
			out_last_q <= push_last;
		end
	end

	assign pixel.valid        = out_valid_q;
	assign pixel.pixel_word   = out_q.pixel_word;
	assign pixel.decode_error = out_q.decode_error;
	assign pixel.end_of_frame = out_q.end_of_frame;
	assign pixel.last_of_byte = out_last_q;

endmodule
